// File: rtl/ggm_pkg.sv
// ----------------------------------------------------------------------------
// ggm_pkg
// Shared types and codes for the greedy graph matching block: request and
// response payloads, the cluster store entry and the action codes.
// ----------------------------------------------------------------------------
package ggm_pkg;

    localparam int NODE_W = 10;
    localparam int ACT_W  = 2;

    // Action codes carried by a request transaction
    localparam logic [ACT_W-1:0] ACT_EDGE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [NODE_W-1:0] source;
        logic [NODE_W-1:0] target;
    } ggm_req_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              assigned;
        logic [NODE_W-1:0] cluster_id;
    } ggm_rsp_t;

    // One cluster store entry: assigned flag and cluster id
    typedef struct packed {
        logic              assigned;
        logic [NODE_W-1:0] id;
    } ggm_entry_t;

endpackage

// File: rtl/ggm_if.sv
// ----------------------------------------------------------------------------
// ggm_if
// Valid/ready channels of the greedy graph matching block: the request
// channel (edge, read, clear) and the response channel (read result).
// ----------------------------------------------------------------------------
interface ggm_req_if;
    import ggm_pkg::*;

    logic     valid;
    logic     ready;
    ggm_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ggm_rsp_if;
    import ggm_pkg::*;

    logic     valid;
    logic     ready;
    ggm_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/greedy_graph_matching.sv
// ----------------------------------------------------------------------------
// greedy_graph_matching
// Greedy pairing of graph nodes into clusters. Edges arrive grouped by source;
// the first unassigned target of a fresh, unassigned source joins its cluster
// under the smaller id. The cluster store is one dual-read, single-write RAM.
// ----------------------------------------------------------------------------
// An accepted edge passes through the evaluate state, and through the second
// write state when it forms a pair. A read waits in the read state until the
// response register is free, then registers its response. An unused action or
// dropped edge stays idle. Requests are taken only in idle; rate is set by the
// single write port of the store and the read-then-write sequence on it. A clear
// sweeps one entry a cycle (NODES, at most 1024); reset starts one as well.
// ----------------------------------------------------------------------------
module greedy_graph_matching #(
    parameter int NODES = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    ggm_req_if.sink       req,
    ggm_rsp_if.source     rsp
);
    import ggm_pkg::*;

    localparam int DEPTH  = (NODES < (1 << NODE_W)) ? NODES : (1 << NODE_W);
    localparam int ADDR_W = $clog2(DEPTH);

    // Sequencer states
    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_EVAL = 3'd2;
    localparam logic [2:0] ST_WR2  = 3'd3;
    localparam logic [2:0] ST_RD   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [NODE_W-1:0] src_reg, src_next;
    logic [NODE_W-1:0] dst_reg, dst_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [NODE_W-1:0] prev_src_reg, prev_src_next;
    logic              prev_valid_reg, prev_valid_next;
    logic              still_reg, still_next;
    logic              rsp_valid_reg, rsp_valid_next;
    ggm_rsp_t          rsp_data_reg, rsp_data_next;

    // Store ports
    ggm_entry_t        mem [DEPTH];
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
    ggm_entry_t        rd_a_reg, rd_b_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    ggm_entry_t        wr_data;

    // Request decode
    logic              accept;
    logic              src_in_range, dst_in_range;
    logic              edge_ok;

    // Edge evaluation
    logic              new_group;
    logic              searching;
    logic              pair;
    logic [NODE_W-1:0] min_id;
    logic              rsp_free;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign src_in_range = (32'(req.data.source) < 32'(NODES));
    assign dst_in_range = (32'(req.data.target) < 32'(NODES));
    assign edge_ok      = src_in_range && dst_in_range
                          && (req.data.source != req.data.target);

    assign rd_addr_a = req.data.source[ADDR_W-1:0];
    assign rd_addr_b = req.data.target[ADDR_W-1:0];

    assign new_group = !prev_valid_reg || (src_reg != prev_src_reg);
    assign searching = new_group ? !rd_a_reg.assigned : still_reg;
    assign pair      = searching && !rd_b_reg.assigned;
    assign min_id    = (src_reg < dst_reg) ? src_reg : dst_reg;

    assign rsp_free  = !rsp_valid_reg || rsp.ready;

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // Cluster store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    // Sequence requests, store writes and the response register
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        rd_ok_next      = rd_ok_reg;
        prev_src_next   = prev_src_reg;
        prev_valid_next = prev_valid_reg;
        still_next      = still_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_data_next   = rsp_data_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = src_reg[ADDR_W-1:0];
        wr_data         = '{assigned: 1'b1, id: min_id};

        unique case (state_reg)
            ST_CLR:
            begin
                // Sweep the store back to unassigned
                wr_en           = 1'b1;
                wr_addr         = clr_cnt_reg;
                wr_data         = '0;
                prev_valid_next = 1'b0;
                still_next      = 1'b0;
                clr_cnt_next    = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    src_next   = req.data.source;
                    dst_next   = req.data.target;
                    rd_ok_next = src_in_range;
                    unique case (req.data.action)
                        ACT_EDGE:
                        begin
                            if (edge_ok)
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_EVAL;
                            end
                        end
                        ACT_READ:
                        begin
                            rd_en      = 1'b1;
                            state_next = ST_RD;
                        end
                        ACT_CLEAR:
                        begin
                            clr_cnt_next    = '0;
                            prev_valid_next = 1'b0;
                            still_next      = 1'b0;
                            state_next      = ST_CLR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EVAL:
            begin
                // Decide the group; on a pair or a fresh unassigned source, write the source entry
                state_next = ST_IDLE;
                if (new_group)
                begin
                    prev_src_next   = src_reg;
                    prev_valid_next = 1'b1;
                end
                if (pair)
                begin
                    wr_en      = 1'b1;
                    wr_data    = '{assigned: 1'b1, id: min_id};
                    still_next = 1'b0;
                    state_next = ST_WR2;
                end
                else if (new_group && !rd_a_reg.assigned)
                begin
                    wr_en      = 1'b1;
                    wr_data    = '{assigned: 1'b1, id: src_reg};
                    still_next = 1'b1;
                end
                else if (new_group)
                begin
                    still_next = 1'b0;
                end
            end
            ST_WR2:
            begin
                // Write the partner entry
                wr_en      = 1'b1;
                wr_addr    = dst_reg[ADDR_W-1:0];
                wr_data    = '{assigned: 1'b1, id: min_id};
                state_next = ST_IDLE;
            end
            ST_RD:
            begin
                // Hold until the response register is free
                if (rsp_free)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_data_next.node     = src_reg;
                    rsp_data_next.assigned = rd_ok_reg && rd_a_reg.assigned;
                    rsp_data_next.cluster_id = (rd_ok_reg && rd_a_reg.assigned)
                                               ? rd_a_reg.id : '0;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            clr_cnt_reg    <= '0;
            prev_src_reg   <= '0;
            prev_valid_reg <= 1'b0;
            still_reg      <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            prev_src_reg   <= prev_src_next;
            prev_valid_reg <= prev_valid_next;
            still_reg      <= still_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        rd_ok_reg    <= rd_ok_next;
        rsp_data_reg <= rsp_data_next;
    end

    // A new response only comes out of the read state
    a_rsp_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_RD))
        else $error("response raised outside read state");

    // An unassigned node always reports cluster id zero
    a_unassigned_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.data.assigned) |-> (rsp.data.cluster_id == '0))
        else $error("unassigned node reports nonzero cluster id");

    // A clear transaction starts the sweep and forgets the current group
    a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.data.action == ACT_CLEAR))
        |=> (state_reg == ST_CLR) && !prev_valid_reg && !still_reg)
        else $error("clear did not start the sweep");

    // A pair always ends the search of its group
    a_pair_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && pair) |=> (state_reg == ST_WR2) && !still_reg)
        else $error("pair did not end the search");

endmodule
